>>> src/dplh_pkg.sv
// Shared types and constants of the dual-path latency histogram.
package dplh_pkg;

  localparam int IN_W  = 144;
  localparam int OUT_W = 232;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_DELAY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_AFTER_NOTIF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE    = 2'd2;

  // function codes carried in tuser
  localparam logic FUNC_PAIR = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // transmit stamp fixup window and flip bit
  localparam logic [31:0] FIXUP_BIT = 32'h0000_1000;
  localparam logic [31:0] FIXUP_LOW = 32'h0000_0e00;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  typedef logic [1:0] op_kind_t;
  localparam op_kind_t OP_PAIR = 2'd0;
  localparam op_kind_t OP_DROP = 2'd1;
  localparam op_kind_t OP_READ = 2'd2;

  typedef struct packed {
    op_kind_t           kind;
    logic signed [31:0] delay_a;
    logic signed [31:0] delay_b;
    logic signed [31:0] delay_diff;
    logic signed [31:0] delay_min;
    logic               found;
    logic               notif;
    logic               skipped;
    logic               fixed_up;
    logic               record;
    logic [15:0]        bin_index;
  } op_t;

endpackage

>>> src/dplh_ram.sv
// Generic simple dual-port RAM with registered read.
module dplh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/dplh_front.sv
// Front end: configuration, input beat intake, classification and delay pipeline.
module dplh_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dplh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dplh_pkg::IN_W-1:0]      s_tdata,
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  input  logic                           clr_busy,
  input  logic                           q_full,
  output logic                           q_push,
  output dplh_pkg::op_t                  q_op
);

  // configuration
  logic signed [31:0] search_delay;
  logic [15:0]        skip_after_notif;
  logic               record_enable;

  // carried state
  logic [31:0] prev_tx;
  logic [15:0] skip_left;
  logic        discarding;

  // input fields
  logic [31:0] rx_a, tx_a, rx_b, tx_b;
  logic [15:0] bin_index;

  // intake decode
  logic               acc;
  logic               notif, both_zero, fix, skip;
  logic [31:0]        tx, txf, d;
  logic [15:0]        sl;
  dplh_pkg::op_kind_t kind;

  // stage 1
  logic               f1_valid;
  dplh_pkg::op_kind_t f1_kind;
  logic [31:0]        f1_rx_a, f1_rx_b, f1_tx;
  logic               f1_notif, f1_fixed, f1_skip, f1_record;
  logic [15:0]        f1_bin;

  // stage 2
  logic               f2_valid;
  dplh_pkg::op_kind_t f2_kind;
  logic signed [31:0] f2_da, f2_db;
  logic               f2_found, f2_notif, f2_fixed, f2_skip, f2_record;
  logic [15:0]        f2_bin;

  // stage 3
  logic               f3_valid;
  dplh_pkg::op_t      f3_op;
  logic               f2_gt;

  logic ready1, ready2, ready3;

  assign rx_a      = s_tdata[31:0];
  assign tx_a      = s_tdata[63:32];
  assign rx_b      = s_tdata[95:64];
  assign tx_b      = s_tdata[127:96];
  assign bin_index = s_tdata[143:128];

  assign ready3   = !f3_valid || !q_full;
  assign ready2   = !f2_valid || ready3;
  assign ready1   = !f1_valid || ready2;
  assign s_tready = ready1 && !clr_busy;
  assign acc      = s_tvalid && s_tready;
  assign q_push   = f3_valid && !q_full;
  assign q_op     = f3_op;

  always_comb begin
    notif     = (tx_a == 32'd0) || (tx_b == 32'd0);
    both_zero = (tx_a == 32'd0) && (tx_b == 32'd0);
    tx        = (tx_a != 32'd0) ? tx_a : tx_b;
    if (notif) begin
      sl = (both_zero && skip_after_notif == 16'd0) ? 16'd1 : skip_after_notif;
    end else begin
      sl = skip_left;
    end
    d    = prev_tx - tx;
    fix  = (d < dplh_pkg::FIXUP_BIT) && (d > dplh_pkg::FIXUP_LOW);
    txf  = fix ? (tx ^ dplh_pkg::FIXUP_BIT) : tx;
    skip = sl != 16'd0;
    if (s_tuser == dplh_pkg::FUNC_READ) begin
      kind = dplh_pkg::OP_READ;
    end else if (discarding || (!notif && tx_a != tx_b)) begin
      kind = dplh_pkg::OP_DROP;
    end else begin
      kind = dplh_pkg::OP_PAIR;
    end
  end

  assign f2_gt = f2_da > f2_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_delay     <= '0;
      skip_after_notif <= '0;
      record_enable    <= 1'b0;
      prev_tx          <= '0;
      skip_left        <= '0;
      discarding       <= 1'b0;
      f1_valid         <= 1'b0;
      f2_valid         <= 1'b0;
      f3_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dplh_pkg::CFG_SEARCH_DELAY:     search_delay     <= cfg_data;
          dplh_pkg::CFG_SKIP_AFTER_NOTIF: skip_after_notif <= cfg_data[15:0];
          dplh_pkg::CFG_RECORD_ENABLE:    record_enable    <= cfg_data[0];
          default: ;
        endcase
      end
      if (acc) begin
        case (kind)
          dplh_pkg::OP_PAIR: begin
            prev_tx   <= txf;
            skip_left <= skip ? 16'(sl - 16'd1) : sl;
          end
          // a dropped beat keeps discarding until the frame ends
          dplh_pkg::OP_DROP: discarding <= !s_tlast;
          default: ;
        endcase
      end
      if (ready1) begin
        f1_valid <= acc;
      end
      if (ready2) begin
        f2_valid <= f1_valid;
      end
      if (ready3) begin
        f3_valid <= f2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_kind   <= kind;
      f1_rx_a   <= rx_a;
      f1_rx_b   <= rx_b;
      f1_tx     <= txf;
      f1_notif  <= notif;
      f1_fixed  <= fix;
      f1_skip   <= skip;
      f1_record <= !skip && record_enable;
      f1_bin    <= bin_index;
    end
    if (f1_valid && ready2) begin
      f2_kind   <= f1_kind;
      f2_da     <= f1_rx_a - f1_tx;
      f2_db     <= f1_rx_b - f1_tx;
      f2_found  <= (32'(f1_rx_a - f1_tx) == search_delay) ||
                   (32'(f1_rx_b - f1_tx) == search_delay);
      f2_notif  <= f1_notif;
      f2_fixed  <= f1_fixed;
      f2_skip   <= f1_skip;
      f2_record <= f1_record;
      f2_bin    <= f1_bin;
    end
    if (f2_valid && ready3) begin
      f3_op.kind       <= f2_kind;
      f3_op.delay_a    <= f2_da;
      f3_op.delay_b    <= f2_db;
      f3_op.delay_diff <= f2_gt ? (f2_da - f2_db) : (f2_db - f2_da);
      f3_op.delay_min  <= f2_gt ? f2_db : f2_da;
      f3_op.found      <= f2_found;
      f3_op.notif      <= f2_notif;
      f3_op.skipped    <= f2_skip;
      f3_op.fixed_up   <= f2_fixed;
      f3_op.record     <= f2_record;
      f3_op.bin_index  <= f2_bin;
    end
  end

endmodule

>>> src/dplh_fifo.sv
// Short operation queue between the front and back ends.
module dplh_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dplh_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output dplh_pkg::op_t pop_op
);

  dplh_pkg::op_t                mem [dplh_pkg::Q_DEPTH];
  logic [dplh_pkg::Q_AW-1:0]    wr_ptr, rd_ptr;
  logic [dplh_pkg::Q_CW-1:0]    count;

  assign full   = count == dplh_pkg::Q_CW'(dplh_pkg::Q_DEPTH);
  assign valid  = count != '0;
  assign pop_op = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

`ifndef SYNTH
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count[dplh_pkg::Q_AW-1:0] == dplh_pkg::Q_AW'(wr_ptr - rd_ptr))
    else $error("queue count out of step with pointers");
`endif
`ifndef SYNTH
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
`endif

endmodule

>>> src/dplh_back.sv
// Back end: histogram read-modify-write, bin reads, clearing pass and output register.
module dplh_back #(
  parameter int BINS = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  dplh_pkg::op_t                q_op,
  output logic                         q_pop,
  output logic                         clr_busy,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dplh_pkg::OUT_W-1:0]   m_tdata
);

  localparam int          AW      = $clog2(BINS);
  localparam logic [31:0] BINS_W  = 32'(BINS);
  localparam logic [AW-1:0] BINS_M1 = AW'(BINS - 1);

  logic [AW-1:0] clr_cnt;
  logic          adv, s2_go, wr_item;
  logic          s2_valid, s2_in_range;
  dplh_pkg::op_t s2_op;
  logic          out_valid;
  logic [dplh_pkg::OUT_W-1:0] out_data, res_data;

  logic [31:0]   rd_bin32;
  logic          rd_in_range;

  logic [31:0]   lane_val [3];
  logic [AW-1:0] raddr    [3];
  logic [31:0]   rdata    [3];
  logic [AW-1:0] s2_addr  [3];
  logic          s2_fwd   [3];
  logic [31:0]   s2_fv    [3];
  logic [31:0]   cur      [3];
  logic [31:0]   nxt      [3];
  logic [31:0]   cnt      [3];

  // clamp negative and oversize values into the top bin
  function automatic logic [AW-1:0] bin_of(input logic [31:0] v);
    if (v[31] || v >= BINS_W) begin
      bin_of = BINS_M1;
    end else begin
      bin_of = v[AW-1:0];
    end
  endfunction

  assign s2_go   = !out_valid || m_tready;
  assign adv     = !s2_valid || s2_go;
  assign q_pop   = adv && q_valid && !clr_busy;
  assign wr_item = s2_valid && s2_go && s2_op.kind == dplh_pkg::OP_PAIR && s2_op.record;

  assign rd_bin32    = {16'd0, q_op.bin_index};
  assign rd_in_range = rd_bin32 < BINS_W;

  assign lane_val[0] = q_op.delay_a;
  assign lane_val[1] = q_op.delay_b;
  assign lane_val[2] = q_op.delay_min;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign raddr[i] = (q_op.kind == dplh_pkg::OP_READ) ? rd_bin32[AW-1:0] : bin_of(lane_val[i]);
    // take the value written in the cycle the read was issued when that write hit the same bin
    assign cur[i]   = s2_fwd[i] ? s2_fv[i] : rdata[i];
    assign nxt[i]   = (&cur[i]) ? cur[i] : cur[i] + 32'd1;
    assign cnt[i]   = (s2_op.kind == dplh_pkg::OP_READ && s2_in_range) ? cur[i] : 32'd0;

    dplh_ram #(
      .WIDTH (32),
      .DEPTH (BINS)
    ) u_hist (
      .clk   (clk),
      .we    (clr_busy || wr_item),
      .waddr (clr_busy ? clr_cnt : s2_addr[i]),
      .wdata (clr_busy ? 32'd0 : nxt[i]),
      .re    (q_pop),
      .raddr (raddr[i]),
      .rdata (rdata[i])
    );

    always_ff @(posedge clk) begin
      if (q_pop) begin
        s2_addr[i] <= raddr[i];
        s2_fwd[i]  <= wr_item && (s2_addr[i] == raddr[i]);
        s2_fv[i]   <= nxt[i];
      end
    end
  end

  always_comb begin
    res_data = '0;
    case (s2_op.kind)
      dplh_pkg::OP_PAIR: begin
        res_data[31:0]   = s2_op.delay_a;
        res_data[63:32]  = s2_op.delay_b;
        res_data[95:64]  = s2_op.delay_diff;
        res_data[127:96] = s2_op.delay_min;
        res_data[128]    = s2_op.found;
        res_data[129]    = s2_op.notif;
        res_data[130]    = s2_op.skipped;
        res_data[132]    = s2_op.fixed_up;
      end
      dplh_pkg::OP_DROP: res_data[131] = 1'b1;
      dplh_pkg::OP_READ: begin
        res_data[164:133] = cnt[0];
        res_data[196:165] = cnt[1];
        res_data[228:197] = cnt[2];
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      clr_busy  <= 1'b1;
      clr_cnt   <= '0;
    end else begin
      if (adv) begin
        s2_valid <= q_pop;
      end
      if (s2_valid && s2_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      // sweep all bins to zero after reset
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == BINS_M1) begin
          clr_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_op       <= q_op;
      s2_in_range <= rd_in_range;
    end
    if (s2_valid && s2_go) begin
      out_data <= res_data;
    end
  end

`ifndef SYNTH
  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !q_pop)
    else $error("operation issued during clearing pass");
`endif
`ifndef SYNTH
  a_fwd_capture: assert property (@(posedge clk) disable iff (rst)
    (wr_item && q_pop && s2_addr[0] == raddr[0]) |=> s2_fwd[0])
    else $error("missed forward on back-to-back bin hit");
`endif
`ifndef SYNTH
  a_sat_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (wr_item && !clr_busy) |-> (nxt[0] != 32'd0 && nxt[1] != 32'd0 && nxt[2] != 32'd0))
    else $error("histogram count wrapped to zero");
`endif
`ifndef SYNTH
  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_busy) |-> $past(clr_cnt) == BINS_M1)
    else $error("clearing pass ended early");
`endif

endmodule

>>> src/dual_path_latency_histogram.sv
// Top level of the dual-path latency histogram.
// Accepts one beat per clock unless held by back-pressure or the clearing pass, and
// returns one result beat per input beat, in order. A beat carries either a timestamp
// pair (tuser 0) or a bin read (tuser 1). Three front stages form the common transmit
// stamp, its fixup, the two path delays, their difference and minimum; a four-deep
// queue follows; then each of the three histogram RAMs does one read and one write per
// cycle, with forwarding between back-to-back hits on one bin, so the sustained rate is
// one beat per cycle while the output is taken. After reset a clearing pass writes zero
// to every bin, and s_tready stays low until it ends; configuration writes are taken
// throughout.
module dual_path_latency_histogram #(
  parameter int BINS = 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dplh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // rx_a[31:0], tx_a[63:32], rx_b[95:64], tx_b[127:96], bin_index[143:128]
  input  logic [dplh_pkg::IN_W-1:0]      s_tdata,
  // func
  input  logic                           s_tuser,
  // frame_end
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // delay_a[31:0], delay_b[63:32], delay_diff[95:64], delay_min[127:96], found[128],
  // notif[129], skipped[130], mismatch[131], fixed_up[132], count_a[164:133],
  // count_b[196:165], count_min[228:197], zero pad[231:229]
  output logic [dplh_pkg::OUT_W-1:0]     m_tdata
);

  logic          clr_busy;
  logic          q_full, q_push, q_pop, q_valid;
  dplh_pkg::op_t push_op, pop_op;

  dplh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .clr_busy  (clr_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  dplh_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_op  (pop_op)
  );

  dplh_back #(
    .BINS (BINS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (pop_op),
    .q_pop    (q_pop),
    .clr_busy (clr_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> bench/dplh_result_check.sv
// Result checker for the dual-path latency histogram: predicts every result beat and compares.
`timescale 1ns / 100ps
module dplh_result_check
  import dplh_pkg::*;
#(
  parameter int HIST_BINS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // rx_a, tx_a, rx_b, tx_b, bin_index
  input  logic [IN_W-1:0]      s_tdata,
  // func
  input  logic                 s_tuser,
  // frame_end
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // delay_a, delay_b, delay_diff, delay_min, found, notif, skipped, mismatch, fixed_up,
  // count_a, count_b, count_min, zero pad
  input  logic [OUT_W-1:0]     m_tdata,
  output int                   failures,
  output int                   pending
);

  typedef struct packed {
    logic [31:0] delay_a;
    logic [31:0] delay_b;
    logic [31:0] delay_diff;
    logic [31:0] delay_min;
    logic        found;
    logic        notif;
    logic        skipped;
    logic        mismatch;
    logic        fixed_up;
    logic [31:0] count_a;
    logic [31:0] count_b;
    logic [31:0] count_min;
  } latency_result_t;

  // configuration as last written
  logic [31:0] search_reg;
  logic [15:0] skip_reg;
  logic        record_reg;

  // predicted block state
  logic [31:0] last_tx_stamp;
  logic [15:0] skip_count;
  logic        frame_dropping;
  logic [31:0] count_path_a [HIST_BINS];
  logic [31:0] count_path_b [HIST_BINS];
  logic [31:0] count_lower  [HIST_BINS];

  latency_result_t pending_latencies [$];

  function automatic int unsigned bin_of(logic [31:0] v);
    if (v[31] || v >= 32'(HIST_BINS)) return HIST_BINS - 1;
    return v;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hffff_ffff) ? c : c + 32'd1;
  endfunction

  function automatic latency_result_t latency_of_beat(logic func, logic [IN_W-1:0] data,
                                                      logic fend);
    latency_result_t r;
    logic [31:0] rxa, txa, rxb, txb, tx, back, da, db;
    logic [15:0] bin;
    logic        pair_notif;
    int unsigned ia, ib, im;
    r   = '0;
    rxa = data[31:0];
    txa = data[63:32];
    rxb = data[95:64];
    txb = data[127:96];
    bin = data[143:128];
    if (func == FUNC_READ) begin
      if (bin < HIST_BINS) begin
        r.count_a   = count_path_a[bin];
        r.count_b   = count_path_b[bin];
        r.count_min = count_lower[bin];
      end
      return r;
    end
    // drop the rest of a frame after a mismatch
    if (frame_dropping) begin
      r.mismatch = 1'b1;
      if (fend) frame_dropping = 1'b0;
      return r;
    end
    pair_notif = (txa == 32'd0) || (txb == 32'd0);
    if (!pair_notif && txa != txb) begin
      r.mismatch     = 1'b1;
      frame_dropping = !fend;
      return r;
    end
    tx = (txa != 32'd0) ? txa : txb;
    if (pair_notif) begin
      skip_count = skip_reg;
      if (txa == 32'd0 && txb == 32'd0 && skip_count == 16'd0) skip_count = 16'd1;
    end
    back = last_tx_stamp - tx;
    if (back < FIXUP_BIT && back > FIXUP_LOW) begin
      tx         = tx ^ FIXUP_BIT;
      r.fixed_up = 1'b1;
    end
    da = rxa - tx;
    db = rxb - tx;
    if ($signed(da) > $signed(db)) begin
      r.delay_diff = da - db;
      r.delay_min  = db;
    end else begin
      r.delay_diff = db - da;
      r.delay_min  = da;
    end
    r.delay_a     = da;
    r.delay_b     = db;
    r.found       = (da == search_reg) || (db == search_reg);
    r.notif       = pair_notif;
    r.skipped     = (skip_count != 16'd0);
    last_tx_stamp = tx;
    if (!r.skipped && record_reg) begin
      ia = bin_of(da);
      ib = bin_of(db);
      im = bin_of(r.delay_min);
      count_path_a[ia] = sat_inc(count_path_a[ia]);
      count_path_b[ib] = sat_inc(count_path_b[ib]);
      count_lower[im]  = sat_inc(count_lower[im]);
    end
    if (skip_count != 16'd0) skip_count = skip_count - 16'd1;
    if (fend) frame_dropping = 1'b0;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $error("%s: expected %h, got %h", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    latency_result_t want, got;
    int bad;
    if (rst) begin
      search_reg     = '0;
      skip_reg       = '0;
      record_reg     = 1'b0;
      last_tx_stamp  = '0;
      skip_count     = '0;
      frame_dropping = 1'b0;
      foreach (count_path_a[i]) begin
        count_path_a[i] = '0;
        count_path_b[i] = '0;
        count_lower[i]  = '0;
      end
      pending_latencies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEARCH_DELAY:     search_reg = cfg_data;
          CFG_SKIP_AFTER_NOTIF: skip_reg   = cfg_data[15:0];
          CFG_RECORD_ENABLE:    record_reg = cfg_data[0];
          default: ;
        endcase
      end
      // compare before predicting: a beat taken now cannot answer at this edge
      if (m_tvalid && m_tready) begin
        got.delay_a    = m_tdata[31:0];
        got.delay_b    = m_tdata[63:32];
        got.delay_diff = m_tdata[95:64];
        got.delay_min  = m_tdata[127:96];
        got.found      = m_tdata[128];
        got.notif      = m_tdata[129];
        got.skipped    = m_tdata[130];
        got.mismatch   = m_tdata[131];
        got.fixed_up   = m_tdata[132];
        got.count_a    = m_tdata[164:133];
        got.count_b    = m_tdata[196:165];
        got.count_min  = m_tdata[228:197];
        if (pending_latencies.size() == 0) begin
          $error("result beat with no item waiting for it");
          failures++;
        end else begin
          want = pending_latencies.pop_front();
          bad  = field_bad("delay_a", want.delay_a, got.delay_a)
               + field_bad("delay_b", want.delay_b, got.delay_b)
               + field_bad("delay_diff", want.delay_diff, got.delay_diff)
               + field_bad("delay_min", want.delay_min, got.delay_min)
               + field_bad("found", 32'(want.found), 32'(got.found))
               + field_bad("notif", 32'(want.notif), 32'(got.notif))
               + field_bad("skipped", 32'(want.skipped), 32'(got.skipped))
               + field_bad("mismatch", 32'(want.mismatch), 32'(got.mismatch))
               + field_bad("fixed_up", 32'(want.fixed_up), 32'(got.fixed_up))
               + field_bad("count_a", want.count_a, got.count_a)
               + field_bad("count_b", want.count_b, got.count_b)
               + field_bad("count_min", want.count_min, got.count_min);
          if (bad != 0) failures++;
        end
      end
      if (s_tvalid && s_tready)
        pending_latencies.push_back(latency_of_beat(s_tuser, s_tdata, s_tlast));
    end
    pending = pending_latencies.size();
  end

endmodule

>>> bench/tb_dual_path_latency_histogram.sv
// Testbench top for the dual-path latency histogram: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_dual_path_latency_histogram;
  import dplh_pkg::*;

  localparam int HIST_BINS        = 65536;
  localparam int RANDOM_PER_PHASE = 400;
  localparam int PHASES           = 5;
  localparam int DRAIN_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT   = 200000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  // rx_a, tx_a, rx_b, tx_b, bin_index
  logic [IN_W-1:0]      s_tdata   = '0;
  // func
  logic                 s_tuser   = 1'b0;
  // frame_end
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  // delay_a, delay_b, delay_diff, delay_min, found, notif, skipped, mismatch, fixed_up,
  // count_a, count_b, count_min, zero pad
  logic [OUT_W-1:0]     m_tdata;

  int          failures;
  int          pending;
  int          idle_cycles = 0;
  logic        send_burst  = 1'b0;
  logic        take_burst  = 1'b0;
  logic [31:0] last_tx     = 32'h1000_0000;

  always #6 clk = ~clk;

  dual_path_latency_histogram #(.BINS(HIST_BINS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  dplh_result_check #(.HIST_BINS(HIST_BINS)) result_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .failures(failures), .pending(pending)
  );

  task automatic write_config(input logic [31:0] search, input logic [15:0] skip,
                              input logic rec);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SEARCH_DELAY;
    cfg_data  <= search;
    @(posedge clk);
    cfg_index <= CFG_SKIP_AFTER_NOTIF;
    cfg_data  <= {16'd0, skip};
    @(posedge clk);
    cfg_index <= CFG_RECORD_ENABLE;
    cfg_data  <= {31'd0, rec};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_beat(input logic func, input logic [31:0] rxa, txa, rxb, txb,
                           input logic fend, input logic [15:0] bin);
    int gap;
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tlast  <= fend;
    s_tdata  <= {bin, txb, rxb, txa, rxa};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly small delays so bins get reused; sometimes negative, past the top bin, or wild
  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return 32'd0 - 32'($urandom_range(1, 64));
      1:       return $urandom();
      2:       return 32'(HIST_BINS) + 32'($urandom_range(0, 1000));
      default: return 32'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic send_random_item();
    int          kind;
    logic [31:0] tx, txa, txb;
    logic [15:0] bin;
    kind = $urandom_range(0, 99);
    // land in the fixup window behind the last stamp now and then
    if ($urandom_range(0, 11) == 0) tx = last_tx - 32'($urandom_range(32'he00, 32'h1000));
    else if ($urandom_range(0, 15) == 0) tx = $urandom();
    else tx = last_tx + 32'($urandom_range(1, 5000));
    if (tx == 32'd0) tx = 32'd1;
    txa = tx;
    txb = tx;
    bin = 16'($urandom_range(0, 65535));
    if (kind < 15) begin
      case ($urandom_range(0, 3))
        0:       bin = 16'hffff;
        1:       bin = 16'($urandom_range(0, 65535));
        default: bin = 16'($urandom_range(0, 63));
      endcase
      send_beat(FUNC_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                1'($urandom_range(0, 1)), bin);
    end else begin
      if (kind < 23) begin
        case ($urandom_range(0, 2))
          0:       txa = 32'd0;
          1:       txb = 32'd0;
          default: begin
            txa = 32'd0;
            txb = 32'd0;
          end
        endcase
      end else if (kind < 29) begin
        txb = tx ^ (32'd1 << $urandom_range(0, 31));
      end
      last_tx = tx;
      send_beat(FUNC_PAIR, tx + pick_delay(), txa, tx + pick_delay(), txb,
                $urandom_range(0, 4) == 0, bin);
    end
  endtask

  // hold ready low for a random stall before each result beat
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 63) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_config(32'd5, 16'd0, 1'b1);

    // fresh histograms read zero, first and top bin
    send_beat(FUNC_READ, '0, '0, '0, '0, 1'b0, 16'd0);
    send_beat(FUNC_READ, '1, '1, '1, '1, 1'b1, 16'hffff);
    // plain pair, delay_a hits the search value
    send_beat(FUNC_PAIR, 32'h1000_0005, 32'h1000_0000, 32'h1000_0009, 32'h1000_0000,
              1'b0, 16'hffff);
    // negative delay and delay past the top bin
    send_beat(FUNC_PAIR, 32'h1000_00fd, 32'h1000_0100, 32'h1001_0100, 32'h1000_0100,
              1'b0, 16'd0);
    // inside the fixup window, then on both of its edges
    send_beat(FUNC_PAIR, 32'h0fff_f202, 32'h0fff_f200, 32'h0fff_f204, 32'h0fff_f200,
              1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h1000_1203, 32'h1000_1200, 32'h1000_1201, 32'h1000_1200,
              1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h1000_0401, 32'h1000_0400, 32'h1000_0402, 32'h1000_0400,
              1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h1000_0404, 32'h1000_0400 - 32'h1000, 32'h1000_0406,
              32'h1000_0400 - 32'h1000, 1'b0, 16'd0);
    // notifications: one stamp zero each way, then both zero forces a skip
    send_beat(FUNC_PAIR, 32'h2000_0003, 32'd0, 32'h2000_0004, 32'h2000_0000, 1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h2000_1003, 32'h2000_1000, 32'h2000_1008, 32'd0, 1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h0000_0010, 32'd0, 32'h0000_0020, 32'd0, 1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h3000_0002, 32'h3000_0000, 32'h3000_0003, 32'h3000_0000,
              1'b0, 16'd0);
    // mismatch mid-frame drops the rest of the frame
    send_beat(FUNC_PAIR, 32'h3000_1002, 32'h3000_1000, 32'h3000_1002, 32'h3000_1001,
              1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h3000_2002, 32'h3000_2000, 32'h3000_2002, 32'h3000_2000,
              1'b0, 16'd0);
    send_beat(FUNC_PAIR, 32'h3000_3002, 32'h3000_3000, 32'h3000_3002, 32'h3000_3000,
              1'b1, 16'd0);
    send_beat(FUNC_PAIR, 32'h3000_4002, 32'h3000_4000, 32'h3000_4003, 32'h3000_4000,
              1'b0, 16'd0);
    // mismatch on the last beat of a frame leaves the next frame alone
    send_beat(FUNC_PAIR, 32'h3000_5002, 32'h3000_5000, 32'h3000_5002, 32'h8000_5000,
              1'b1, 16'd0);
    send_beat(FUNC_PAIR, 32'h3000_6001, 32'h3000_6000, 32'h3000_6001, 32'h3000_6000,
              1'b0, 16'd0);
    // all-ones stamps and wrapping delays
    send_beat(FUNC_PAIR, 32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
              1'b1, 16'hffff);
    send_beat(FUNC_PAIR, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001,
              1'b0, 16'd0);
    // read back what was recorded
    send_beat(FUNC_READ, '0, '0, '0, '0, 1'b0, 16'd5);
    send_beat(FUNC_READ, '0, '0, '0, '0, 1'b0, 16'd9);
    send_beat(FUNC_READ, '0, '0, '0, '0, 1'b0, 16'd1);
    send_beat(FUNC_READ, '0, '0, '0, '0, 1'b0, 16'd2);
    send_beat(FUNC_READ, '0, '0, '0, '0, 1'b1, 16'hffff);

    last_tx = 32'h4000_0000;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       write_config(32'h8000_0000, 16'd3, 1'b1);
        1:       write_config(32'd7, 16'hffff, 1'b1);
        2:       write_config(32'h7fff_ffff, 16'd0, 1'b0);
        3:       write_config(32'($urandom_range(0, 63)), 16'($urandom_range(1, 10)), 1'b1);
        default: write_config(32'd0, 16'd1, 1'b1);
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_item();
    end
    drain_results();

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
